// File: src/rwlt_pkg.sv
// ----------------------------------------------------------------------------
// rwlt_pkg
// Types, constants and codes shared by the reader-writer lock table.
// ----------------------------------------------------------------------------
package rwlt_pkg;

	localparam int NUM_LOCKS = 64;
	localparam int ID_BITS = 16;
	localparam int COUNT_BITS = 16;
	localparam int ADDR_W = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	localparam logic [1:0] KIND_ACQ_SH = 2'd0;
	localparam logic [1:0] KIND_ACQ_EX = 2'd1;
	localparam logic [1:0] KIND_REL_SH = 2'd2;
	localparam logic [1:0] KIND_REL_EX = 2'd3;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_BUSY = 2'd1;
	localparam logic [1:0] ST_WAITER = 2'd2;
	localparam logic [1:0] ST_BAD = 2'd3;

	typedef struct packed {
		logic [COUNT_BITS-1:0] count;
		logic shared;
		logic excl;
		logic wait_flag;
		logic [ID_BITS-1:0] owner;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic [1:0] kind;
		logic [ID_BITS-1:0] who;
		logic blocking;
		logic in_range;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic wake;
		logic [COUNT_BITS-1:0] count;
		logic excl;
	} resp_t;

endpackage

// File: src/rwlt_ram.sv
// ----------------------------------------------------------------------------
// rwlt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rwlt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: src/rwlt_update.sv
// ----------------------------------------------------------------------------
// rwlt_update
// Applies one lock request to the entry read from the table and forms the
// new entry and the response.
// ----------------------------------------------------------------------------
module rwlt_update import rwlt_pkg::*; (
	input  req_t   req,
	input  entry_t cur,
	output entry_t nxt,
	output resp_t  resp
);

	logic free;
	logic [1:0] status;
	logic wake;

	assign free = (cur.count == '0) && !cur.shared && !cur.excl && !cur.wait_flag;

	always_comb begin
		nxt = cur;
		status = ST_DONE;
		wake = 1'b0;
		unique case (req.kind)
			KIND_ACQ_SH: begin
				if (!cur.excl && (cur.count != COUNT_MAX)) begin
					nxt.count = cur.count + COUNT_BITS'(1);
					nxt.shared = 1'b1;
				end else if (req.blocking) begin
					nxt.wait_flag = 1'b1;
					status = ST_WAITER;
				end else begin
					status = ST_BUSY;
				end
			end
			KIND_ACQ_EX: begin
				if (free) begin
					nxt.excl = 1'b1;
					nxt.owner = req.who;
				end else if (req.blocking) begin
					nxt.wait_flag = 1'b1;
					status = ST_WAITER;
				end else begin
					status = ST_BUSY;
				end
			end
			KIND_REL_SH: begin
				if (!((cur.count != '0) && cur.shared)) begin
					status = ST_BAD;
				end else begin
					nxt.count = cur.count - COUNT_BITS'(1);
					if (nxt.count == '0) begin
						wake = cur.wait_flag;
						nxt.shared = 1'b0;
						nxt.excl = 1'b0;
						nxt.wait_flag = 1'b0;
					end
				end
			end
			default: begin
				if (!(cur.excl && (cur.owner == req.who))) begin
					status = ST_BAD;
				end else begin
					wake = cur.wait_flag;
					nxt.count = '0;
					nxt.shared = 1'b0;
					nxt.excl = 1'b0;
					nxt.wait_flag = 1'b0;
				end
			end
		endcase

		if (req.in_range) begin
			resp.status = status;
			resp.wake = wake;
			resp.count = nxt.count;
			resp.excl = nxt.excl;
		end else begin
			resp.status = (req.kind == KIND_ACQ_SH || req.kind == KIND_ACQ_EX) ? ST_BUSY : ST_BAD;
			resp.wake = 1'b0;
			resp.count = '0;
			resp.excl = 1'b0;
		end
	end

endmodule

// File: src/reader_writer_lock_table.sv
// ----------------------------------------------------------------------------
// reader_writer_lock_table
// Hardware lock manager: a table of reader-writer locks in one RAM.
//
// A request beat is taken at a clock edge with start high and busy low; it
// carries kind, lock_index, requester and blocking. The addressed entry is
// read from the table RAM at that edge, modified in the next cycle and
// written back at the following edge, where the response is registered.
// done is high for exactly one cycle with status, wake_waiters,
// reader_count and held_exclusive; the receiver cannot stall it.
// A new request is not taken until the read-modify-write of the table RAM
// for the previous one is done; busy is high in the cycle between request
// and response.
// Reset clears one valid flop per lock at once, so every lock reads as free;
// no clearing pass is needed and a request may be issued right after reset.
// ----------------------------------------------------------------------------
module reader_writer_lock_table import rwlt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            kind,
	input  logic [5:0]            lock_index,
	input  logic [15:0]           requester,
	input  logic                  blocking,
	output logic                  done,
	output logic [1:0]            status,
	output logic                  wake_waiters,
	output logic [COUNT_BITS-1:0] reader_count,
	output logic                  held_exclusive
);

	logic accept;
	logic valid_s1;
	req_t req_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [ENTRY_W-1:0] rdata;
	logic [NUM_LOCKS-1:0] live_q;
	entry_t cur;
	entry_t nxt;
	resp_t resp;
	logic done_q;
	resp_t resp_q;
	logic [ADDR_W-1:0] addr_in;
	logic in_range;

	assign accept = start && !busy;
	assign busy = valid_s1;
	assign addr_in = ADDR_W'(lock_index);
	assign in_range = (32'(lock_index) < NUM_LOCKS);

	rwlt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(NUM_LOCKS),
		.AW(ADDR_W)
	) u_table (
		.clk(clk),
		.we(valid_s1 && req_s1.in_range),
		.waddr(addr_s1),
		.wdata(nxt),
		.re(accept),
		.raddr(addr_in),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1.kind <= kind;
			req_s1.who <= requester[ID_BITS-1:0];
			req_s1.blocking <= blocking;
			req_s1.in_range <= in_range;
			addr_s1 <= addr_in;
		end
	end

	// entries never written read as free
	assign cur = (req_s1.in_range && live_q[addr_s1]) ? entry_t'(rdata) : '0;

	rwlt_update u_update (
		.req(req_s1),
		.cur(cur),
		.nxt(nxt),
		.resp(resp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
			if (valid_s1 && req_s1.in_range) begin
				live_q[addr_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			resp_q <= resp;
		end
	end

	assign done = done_q;
	assign status = resp_q.status;
	assign wake_waiters = resp_q.wake;
	assign reader_count = resp_q.count;
	assign held_exclusive = resp_q.excl;

endmodule
